// File: hw/rtl/cobsrx_pkg.sv
package cobsrx_pkg;

  localparam int ENC_MAX_DEF     = 512;
  localparam int DEC_MAX_DEF     = 384;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int MIN_LEN_W = 9;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;
  localparam logic [7:0]  CODE_FULL_GROUP = 8'hFF;

  // register indexes (byte address = 4 * index)
  localparam logic REG_ENABLE  = 1'b0;
  localparam logic REG_MIN_LEN = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_ABORT = 2'd3
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } res_tag_t;

endpackage

// File: hw/rtl/cobsrx_front.sv
module cobsrx_front #(
  parameter int ENC_MAX = 512,
  parameter int DEC_MAX = 384,
  parameter int DEC_W   = $clog2(DEC_MAX + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [7:0]                 in_byte,
  input  logic                       enable,
  input  logic [cobsrx_pkg::MIN_LEN_W-1:0] min_len,
  output cobsrx_pkg::res_tag_t       res_tag,
  output logic [7:0]                 res_data,
  output logic [DEC_W-1:0]           res_len
);
  import cobsrx_pkg::*;

  localparam int ENC_W = $clog2(ENC_MAX + 1);
  localparam int CMP_W = (DEC_W > MIN_LEN_W) ? DEC_W : MIN_LEN_W;

  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_MSB) != 16'h0000) begin
        v = (v << 1) ^ CRC_POLY;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

  logic [ENC_W-1:0] enc_count, enc_count_next;
  logic [7:0]       group_left, group_left_next;
  logic             zero_pending, zero_pending_next;
  logic [15:0]      crc_lag, crc_lag_next;
  logic [7:0]       hold_older, hold_older_next;
  logic [7:0]       hold_newer, hold_newer_next;
  logic [1:0]       hold_fill, hold_fill_next;
  logic [DEC_W-1:0] dec_count, dec_count_next;
  logic             frame_bad, frame_bad_next;

  logic             do_push;
  logic [7:0]       push_val;
  logic [CMP_W-1:0] need;
  logic [CMP_W-1:0] dec_wide;
  logic             good;

  always_comb begin
    enc_count_next    = enc_count;
    group_left_next   = group_left;
    zero_pending_next = zero_pending;
    crc_lag_next      = crc_lag;
    hold_older_next   = hold_older;
    hold_newer_next   = hold_newer;
    hold_fill_next    = hold_fill;
    dec_count_next    = dec_count;
    frame_bad_next    = frame_bad;
    res_tag           = '{valid: 1'b0, kind: KIND_DATA};
    res_data          = 8'h00;
    res_len           = '0;
    do_push           = 1'b0;
    push_val          = 8'h00;

    // floor of 2 on the minimum length
    need     = (min_len < MIN_LEN_W'(2)) ? CMP_W'(2) : CMP_W'(min_len);
    dec_wide = CMP_W'(dec_count);
    good     = !frame_bad && (group_left == 8'h00) && (dec_wide >= need) &&
               (hold_fill == 2'd2) && ({hold_newer, hold_older} == crc_lag);

    if (in_valid && enable) begin
      if (in_byte == 8'h00) begin
        if (enc_count != '0) begin
          res_tag = '{valid: 1'b1, kind: (good ? KIND_GOOD : KIND_BAD)};
          res_len = dec_count;
        end
        enc_count_next    = '0;
        group_left_next   = 8'h00;
        zero_pending_next = 1'b0;
        crc_lag_next      = CRC_INIT;
        hold_older_next   = 8'h00;
        hold_newer_next   = 8'h00;
        hold_fill_next    = 2'd0;
        dec_count_next    = '0;
        frame_bad_next    = 1'b0;
      end else if (enc_count >= ENC_W'(ENC_MAX)) begin
        res_tag           = '{valid: 1'b1, kind: KIND_ABORT};
        res_len           = dec_count;
        enc_count_next    = '0;
        group_left_next   = 8'h00;
        zero_pending_next = 1'b0;
        crc_lag_next      = CRC_INIT;
        hold_older_next   = 8'h00;
        hold_newer_next   = 8'h00;
        hold_fill_next    = 2'd0;
        dec_count_next    = '0;
        frame_bad_next    = 1'b0;
      end else begin
        enc_count_next = enc_count + ENC_W'(1);
        if (group_left == 8'h00) begin
          // code byte: owed zero goes out only now that another group follows
          do_push           = zero_pending;
          push_val          = 8'h00;
          zero_pending_next = (in_byte != CODE_FULL_GROUP);
          group_left_next   = in_byte - 8'd1;
        end else begin
          group_left_next = group_left - 8'd1;
          do_push         = 1'b1;
          push_val        = in_byte;
        end

        if (do_push) begin
          if (dec_count >= DEC_W'(DEC_MAX)) begin
            frame_bad_next = 1'b1;
          end else begin
            dec_count_next = dec_count + DEC_W'(1);
            if (hold_fill == 2'd2) begin
              crc_lag_next = crc_feed(crc_lag, hold_older);
              res_tag      = '{valid: 1'b1, kind: KIND_DATA};
              res_data     = hold_older;
            end
            hold_older_next = hold_newer;
            hold_newer_next = push_val;
            if (hold_fill != 2'd2) begin
              hold_fill_next = hold_fill + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_count    <= '0;
      group_left   <= 8'h00;
      zero_pending <= 1'b0;
      crc_lag      <= CRC_INIT;
      hold_older   <= 8'h00;
      hold_newer   <= 8'h00;
      hold_fill    <= 2'd0;
      dec_count    <= '0;
      frame_bad    <= 1'b0;
    end else begin
      enc_count    <= enc_count_next;
      group_left   <= group_left_next;
      zero_pending <= zero_pending_next;
      crc_lag      <= crc_lag_next;
      hold_older   <= hold_older_next;
      hold_newer   <= hold_newer_next;
      hold_fill    <= hold_fill_next;
      dec_count    <= dec_count_next;
      frame_bad    <= frame_bad_next;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    res_tag.valid && (res_tag.kind != KIND_DATA) |=> (enc_count == '0) && (hold_fill == 2'd0))
    else $error("frame state not cleared after frame end");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    hold_fill != 2'd3)
    else $error("delay line fill out of range");

  a_dec_limit: assert property (@(posedge clk) disable iff (rst)
    dec_count <= DEC_W'(DEC_MAX))
    else $error("decoded count past limit");

endmodule

// File: hw/rtl/cobsrx_queue.sv
module cobsrx_queue #(
  parameter int W     = 19,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         not_full,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  import cobsrx_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign not_full  = (count < CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> not_full)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count past depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count lost a push");

endmodule

// File: hw/rtl/cobs_crc16_frame_receiver_top.sv
// COBS frame receiver with CRC-16/CCITT-FALSE trailer check.
// Input stream: one link byte per beat on s_tdata; a zero byte ends a frame.
// Output stream: one beat per decoded byte (m_tuser = data) and one status
// beat per non-empty frame (good, bad or aborted), with frame_length set.
// The two trailer bytes are never sent as data: each decoded byte leaves two
// decoded positions late, and the trailer is checked at the delimiter.
// Config (APB, always ready): 0x0 enable, 0x4 min_decoded_len. Write only
// while the stream is idle.
// Path: a result caused by an accepted byte is written into the queue at the
// accept edge and drives m_tvalid (one register stage, the queue entry).
// Throughput: one byte per cycle while s_tready is high. The whole decode,
// counting and byte-wide CRC update happen in the front stage on accept.
// Stall: results wait in a QUEUE_DEPTH-entry queue; s_tready drops only when
// that queue is full, so a stalled sink holds back the link side then.
// Reset: enable=1, min_decoded_len=2, frame state cleared, queue empty.
// With enable clear, beats are still taken but ignored and state is held.
module cobs_crc16_frame_receiver_top #(
  parameter int ENC_MAX     = cobsrx_pkg::ENC_MAX_DEF,
  parameter int DEC_MAX     = cobsrx_pkg::DEC_MAX_DEF,
  parameter int QUEUE_DEPTH = cobsrx_pkg::QUEUE_DEPTH_DEF,
  parameter int DEC_W       = $clog2(DEC_MAX + 1),
  parameter int TD_W        = ((8 + DEC_W + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  // link side
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] link_byte
  // result side
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [TD_W-1:0] m_tdata,   // [7:0] data_byte, then frame_length, zero pad
  output logic [1:0]      m_tuser,   // [1:0] kind
  // config port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import cobsrx_pkg::*;

  localparam int QW = 2 + 8 + DEC_W;

  logic                 enable;
  logic [MIN_LEN_W-1:0] min_len;
  logic                 cfg_wr;

  res_tag_t             res_tag;
  logic [7:0]           res_data;
  logic [DEC_W-1:0]     res_len;
  logic                 in_beat;
  logic [QW-1:0]        q_out;

  // --- config registers ---
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b1;
      min_len <= MIN_LEN_W'(2);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ENABLE:  enable  <= pwdata[0];
        REG_MIN_LEN: min_len <= pwdata[MIN_LEN_W-1:0];
        default:     enable  <= enable;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ENABLE:  prdata = {31'd0, enable};
      REG_MIN_LEN: prdata = {{(32 - MIN_LEN_W){1'b0}}, min_len};
      default:     prdata = 32'd0;
    endcase
  end

  // --- front: decode, delay line, CRC, frame checks ---
  assign in_beat = s_tvalid && s_tready;

  cobsrx_front #(
    .ENC_MAX (ENC_MAX),
    .DEC_MAX (DEC_MAX),
    .DEC_W   (DEC_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_beat),
    .in_byte  (s_tdata),
    .enable   (enable),
    .min_len  (min_len),
    .res_tag  (res_tag),
    .res_data (res_data),
    .res_len  (res_len)
  );

  // --- back: result queue drives the output stream ---
  cobsrx_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_tag.valid),
    .push_data ({res_len, res_data, res_tag.kind}),
    .not_full  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (q_out)
  );

  assign m_tuser = q_out[1:0];
  assign m_tdata = {{(TD_W - 8 - DEC_W){1'b0}}, q_out[QW-1:2]};

endmodule

// File: tb/sv/tb_cobs_crc16_frame_receiver_top.sv
`timescale 1ns / 1ps

module tb_cobs_crc16_frame_receiver_top;
  import cobsrx_pkg::*;

  localparam int DEC_W = $clog2(DEC_MAX_DEF + 1);
  localparam int TD_W  = ((8 + DEC_W + 7) / 8) * 8;
  localparam int RUN_LIMIT = 1_000_000;

  localparam logic [2:0] ADDR_ENABLE  = {REG_ENABLE, 2'b00};
  localparam logic [2:0] ADDR_MIN_LEN = {REG_MIN_LEN, 2'b00};

  typedef logic [7:0] byte_q_t[$];

  // one result beat as the receiver should emit it
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [8:0]  len;
  } rx_result_t;

  // how a generated frame gets damaged on its way to the link
  typedef enum int {
    FLAW_NONE,
    FLAW_CRC,
    FLAW_FLIP,
    FLAW_CUT,
    FLAW_NO_DELIM
  } flaw_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [7:0]      s_tdata = 8'h00;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [TD_W-1:0] m_tdata;   // [7:0] data_byte, [16:8] frame_length, zero pad
  logic [1:0]      m_tuser;   // [1:0] kind
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [2:0]      paddr = 3'd0;
  logic [31:0]     pwdata = 32'd0;
  logic [31:0]     prdata;
  logic            pready;

  cobs_crc16_frame_receiver_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // link bytes waiting for the driver, and results still owed by the block
  byte_q_t    link_pending;
  rx_result_t rx_results_due[$];

  // shadow of the receiver: registers and frame state
  logic        cfg_enable = 1'b1;
  logic [8:0]  cfg_min_len = 9'd2;
  logic [9:0]  enc_cnt;
  logic [7:0]  grp_left;
  logic        zero_owed;
  logic [15:0] crc_run;
  logic [7:0]  dly_old;
  logic [7:0]  dly_new;
  logic [1:0]  dly_fill;
  logic [8:0]  dec_cnt;
  logic        over_limit;

  // handshake flags from the last rising edge, read by the falling-edge drivers
  logic link_took = 1'b0;
  logic res_took = 1'b0;
  int   link_gap = 0;
  int   link_calm = 0;
  int   sink_gap = 0;
  int   sink_calm = 0;

  int cycle_cnt = 0;
  int beats_queued = 0;
  int beats_taken = 0;
  int n_fail = 0;
  int n_data = 0;
  int n_good = 0;
  int n_bad = 0;
  int n_abort = 0;
  rx_result_t want;

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    int          k;
    v = c ^ {b, 8'h00};
    for (k = 0; k < 8; k++)
      v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    return v;
  endfunction

  // mostly back-to-back, sometimes a few cycles, rarely long; calm runs force zero gaps
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  function automatic void clear_frame();
    enc_cnt    = '0;
    grp_left   = '0;
    zero_owed  = 1'b0;
    crc_run    = CRC_INIT;
    dly_old    = '0;
    dly_new    = '0;
    dly_fill   = '0;
    dec_cnt    = '0;
    over_limit = 1'b0;
  endfunction

  function automatic void owe_result(input kind_t kind, input logic [7:0] data,
                                     input logic [8:0] len);
    rx_result_t r;
    r.kind = kind;
    r.data = data;
    r.len  = len;
    rx_results_due.push_back(r);
  endfunction

  // decoded byte enters the two-deep delay line; the byte it pushes out is
  // emitted and folded into the running CRC
  function automatic void push_decoded(input logic [7:0] b);
    if (dec_cnt >= 9'(DEC_MAX_DEF)) begin
      over_limit = 1'b1;
      return;
    end
    dec_cnt++;
    if (dly_fill >= 2'd2) begin
      crc_run = crc16_step(crc_run, dly_old);
      owe_result(KIND_DATA, dly_old, 9'd0);
    end
    dly_old = dly_new;
    dly_new = b;
    if (dly_fill < 2'd2) dly_fill++;
  endfunction

  function automatic void decode_link_byte(input logic [7:0] b);
    logic [8:0] need;
    logic       ok;
    if (!cfg_enable) return;
    if (b == 8'h00) begin
      if (enc_cnt == '0) begin
        clear_frame();
        return;
      end
      need = (cfg_min_len < 9'd2) ? 9'd2 : cfg_min_len;
      ok = !over_limit && grp_left == '0 && dec_cnt >= need && dly_fill >= 2'd2;
      // trailer is little-endian: older byte is the low half
      if (ok) ok = ({dly_new, dly_old} == crc_run);
      owe_result(ok ? KIND_GOOD : KIND_BAD, 8'h00, dec_cnt);
      clear_frame();
      return;
    end
    if (enc_cnt >= 10'(ENC_MAX_DEF)) begin
      owe_result(KIND_ABORT, 8'h00, dec_cnt);
      clear_frame();
      return;
    end
    enc_cnt++;
    if (grp_left == '0) begin
      // code byte: settles the zero owed by the previous group
      if (zero_owed) push_decoded(8'h00);
      zero_owed = (b != CODE_FULL_GROUP);
      grp_left  = b - 8'd1;
    end else begin
      grp_left--;
      push_decoded(b);
    end
  endfunction

  function automatic byte_q_t cobs_pack(input byte_q_t raw);
    byte_q_t out;
    byte_q_t grp;
    int      i;
    int      j;
    for (i = 0; i <= raw.size(); i++) begin
      if (i < raw.size() && raw[i] != 8'h00) grp.push_back(raw[i]);
      // 254 data bytes close a group with code 0xFF, same formula
      if (i == raw.size() || raw[i] == 8'h00 || grp.size() == 254) begin
        out.push_back(8'(grp.size() + 1));
        for (j = 0; j < grp.size(); j++) out.push_back(grp[j]);
        grp.delete();
      end
    end
    return out;
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    link_pending.push_back(b);
    beats_queued++;
  endtask

  task automatic send_frame(input byte_q_t pl, input flaw_t flaw);
    byte_q_t     enc;
    logic [15:0] crc;
    int          k;
    crc = CRC_INIT;
    for (k = 0; k < pl.size(); k++) crc = crc16_step(crc, pl[k]);
    if (flaw == FLAW_CRC) crc = crc ^ 16'(1 << $urandom_range(0, 15));
    pl.push_back(crc[7:0]);
    pl.push_back(crc[15:8]);
    enc = cobs_pack(pl);
    if (flaw == FLAW_FLIP) begin
      k = $urandom_range(0, enc.size() - 1);
      enc[k] = enc[k] ^ 8'(1 << $urandom_range(0, 7));
    end else if (flaw == FLAW_CUT) begin
      k = $urandom_range(1, 3);
      while (k > 0 && enc.size() > 1) begin
        void'(enc.pop_back());
        k--;
      end
    end
    for (k = 0; k < enc.size(); k++) queue_byte(enc[k]);
    if (flaw != FLAW_NO_DELIM) queue_byte(8'h00);
  endtask

  // mostly well-formed frames with random content; the rest damaged frames,
  // bare delimiters and raw noise
  task automatic random_traffic(input int n_beats);
    byte_q_t pl;
    int      start;
    int      r;
    int      len;
    int      zpct;
    int      i;
    flaw_t   flaw;
    start = beats_queued;
    while (beats_queued - start < n_beats) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        r = $urandom_range(0, 99);
        len = (r < 80) ? $urandom_range(0, 12) :
              (r < 98) ? $urandom_range(13, 60) : $urandom_range(61, 200);
        case ($urandom_range(0, 3))
          0: zpct = 0;
          1: zpct = 8;
          2: zpct = 35;
          default: zpct = 85;
        endcase
        pl.delete();
        for (i = 0; i < len; i++)
          pl.push_back(($urandom_range(0, 99) < zpct) ? 8'h00 : 8'($urandom_range(1, 255)));
        r = $urandom_range(0, 99);
        flaw = (r < 60) ? FLAW_NONE : (r < 72) ? FLAW_CRC : (r < 80) ? FLAW_FLIP :
               (r < 88) ? FLAW_CUT : FLAW_NO_DELIM;
        send_frame(pl, flaw);
      end else if (r < 94) begin
        repeat ($urandom_range(1, 3)) queue_byte(8'h00);
      end else begin
        repeat ($urandom_range(1, 10)) queue_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // all bytes sent, all results in, then let the one-stage pipe settle
  task automatic wait_idle();
    while (link_pending.size() != 0 || s_tvalid || rx_results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // link driver: next byte after a random gap, held until taken
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || link_took)) begin
      if (link_gap > 0) begin
        link_gap--;
        s_tvalid <= 1'b0;
      end else if (link_pending.size() > 0) begin
        s_tdata  <= link_pending.pop_front();
        s_tvalid <= 1'b1;
        link_gap = pick_gap(link_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink: may stall after a taken beat, sometimes for long stretches
  always @(negedge clk) begin
    if (res_took && sink_gap == 0) sink_gap = pick_gap(sink_calm);
    if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: results are checked before the same edge's link beat is decoded
  always @(posedge clk) begin
    link_took = 1'b0;
    res_took  = 1'b0;
    if (!rst) begin
      cycle_cnt++;
      if (cycle_cnt >= RUN_LIMIT) begin
        $display("FAIL cobs_crc16_frame_receiver_top");
        $finish;
      end else begin
        if (m_tvalid && m_tready) begin
          res_took = 1'b1;
          case (kind_t'(m_tuser))
            KIND_DATA: n_data++;
            KIND_GOOD: n_good++;
            KIND_BAD:  n_bad++;
            default:   n_abort++;
          endcase
          if (rx_results_due.size() == 0) begin
            $error("result beat with nothing owed: kind %0d data %0h length %0d",
                   m_tuser, m_tdata[7:0], m_tdata[8 +: DEC_W]);
            n_fail++;
          end else begin
            want = rx_results_due.pop_front();
            if (m_tuser !== want.kind) begin
              $error("kind: expected %0d, got %0d", want.kind, m_tuser);
              n_fail++;
            end
            if (m_tdata[7:0] !== want.data) begin
              $error("data_byte: expected %0h, got %0h", want.data, m_tdata[7:0]);
              n_fail++;
            end
            if (m_tdata[8 +: DEC_W] !== want.len) begin
              $error("frame_length: expected %0d, got %0d", want.len, m_tdata[8 +: DEC_W]);
              n_fail++;
            end
            if (m_tdata[TD_W-1:8+DEC_W] !== '0) begin
              $error("tdata pad: expected 0, got %0h", m_tdata[TD_W-1:8+DEC_W]);
              n_fail++;
            end
          end
        end
        if (psel && penable && pwrite && pready) begin
          if (paddr == ADDR_ENABLE) cfg_enable = pwdata[0];
          else if (paddr == ADDR_MIN_LEN) cfg_min_len = pwdata[8:0];
        end
        if (s_tvalid && s_tready) begin
          link_took = 1'b1;
          beats_taken++;
          decode_link_byte(s_tdata);
        end
      end
    end
  end

  initial begin
    byte_q_t pl;
    int      i;
    clear_frame();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    reg_write(ADDR_ENABLE, 32'd1);
    reg_write(ADDR_MIN_LEN, 32'd2);

    // directed: empty frame, code byte only (too short), group cut by the
    // delimiter, full-group code cut short, trailer-only good frame, payload
    // with zero and 0xFF, bad CRC
    queue_byte(8'h00);
    queue_byte(8'h01);
    queue_byte(8'h00);
    queue_byte(8'h03);
    queue_byte(8'hAA);
    queue_byte(8'h00);
    queue_byte(CODE_FULL_GROUP);
    queue_byte(8'h00);
    pl.delete();
    send_frame(pl, FLAW_NONE);
    pl = '{8'h00, 8'hFF};
    send_frame(pl, FLAW_NONE);
    pl = '{8'h55};
    send_frame(pl, FLAW_CRC);
    wait_idle();

    // min length below 2 must behave as 2
    reg_write(ADDR_MIN_LEN, 32'd0);
    random_traffic(80);
    wait_idle();
    reg_write(ADDR_MIN_LEN, 32'd1);
    random_traffic(60);
    wait_idle();
    // large minimums: nearly every frame fails the length check
    reg_write(ADDR_MIN_LEN, 32'd384);
    random_traffic(40);
    wait_idle();
    reg_write(ADDR_MIN_LEN, 32'h1FF);
    random_traffic(30);
    wait_idle();

    // frame left open across a disabled stretch; its delimiter comes later
    reg_write(ADDR_MIN_LEN, 32'd2);
    pl.delete();
    for (i = 0; i < 6; i++) pl.push_back(8'($urandom_range(0, 255)));
    send_frame(pl, FLAW_NO_DELIM);
    wait_idle();
    reg_write(ADDR_ENABLE, 32'd0);
    random_traffic(40);
    wait_idle();
    reg_write(ADDR_ENABLE, 32'd1);
    queue_byte(8'h00);
    wait_idle();

    reg_write(ADDR_MIN_LEN, 32'($urandom_range(3, 30)));
    random_traffic(100);
    wait_idle();

    // limits: exactly DEC_MAX decoded (full group followed by a zero), one
    // past DEC_MAX, then ENC_MAX encoded bytes plus one to force an abort
    reg_write(ADDR_MIN_LEN, 32'd2);
    pl.delete();
    for (i = 0; i < DEC_MAX_DEF - 2; i++)
      pl.push_back((i == 254) ? 8'h00 : 8'($urandom_range(1, 255)));
    send_frame(pl, FLAW_NONE);
    pl.delete();
    for (i = 0; i < DEC_MAX_DEF - 1; i++) pl.push_back(8'($urandom_range(1, 255)));
    send_frame(pl, FLAW_NONE);
    for (i = 0; i <= ENC_MAX_DEF; i++) queue_byte(8'($urandom_range(1, 255)));
    pl = '{8'h12, 8'h00, 8'h34};
    send_frame(pl, FLAW_NONE);
    wait_idle();

    random_traffic(70);
    wait_idle();
    repeat (10) @(negedge clk);

    $display("Covered %0d link beats: enable on/off, min length 0..511, decode and encode limits",
             beats_taken);
    $display("Results seen: %0d data, %0d good, %0d bad, %0d aborted; %0d mismatches",
             n_data, n_good, n_bad, n_abort, n_fail);
    if (n_fail == 0) begin
      $display("PASS cobs_crc16_frame_receiver_top");
    end else begin
      $display("FAIL cobs_crc16_frame_receiver_top");
    end
    $finish;
  end

endmodule
